// ===== rtl/core/dstg_pkg.sv =====
package dstg_pkg;

  localparam int unsigned PRECISION = 16;
  localparam int unsigned PERIOD_W = 24;
  localparam int unsigned RATE_W = 16;
  localparam int unsigned INC_W = 16;
  localparam int unsigned HZ_W = 15;
  localparam int unsigned CYC_W = 6;
  localparam int unsigned TIMER_W = PERIOD_W + 2;
  localparam int unsigned CNT_W = 6;

  localparam logic [CNT_W-1:0] MAX_SAMPLES = 6'd63;
  localparam logic [PERIOD_W-1:0] MIN_PERIOD = 24'd16;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd640;
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd44100;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP = 2'd2,
    CMD_STOP_ALL = 2'd3
  } cmd_t;

  typedef enum logic {
    CFG_SAMPLE_PERIOD = 1'b0,
    CFG_SOUND_RATE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    cmd_t command;
    logic channel;
    logic [HZ_W-1:0] tone_hz;
    logic [CYC_W-1:0] cyc_elapsed;
  } in_word_t;

  typedef struct packed {
    logic signed [2:0] sample;
    logic last;
  } out_word_t;

  typedef struct packed {
    logic set_inc;
    logic clr_one;
    logic clr_all;
    logic ch;
    logic step;
  } voice_ctl_t;

endpackage

// ===== rtl/core/dstg_div.sv =====
module dstg_div
  import dstg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [HZ_W-1:0]   tone_hz,
  input  logic [RATE_W-1:0] divisor,
  output logic              done,
  output logic [INC_W-1:0]  quotient
);

  localparam int unsigned DVD_W = HZ_W + INC_W;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [RATE_W-1:0] rem_r, rem_nxt;
  logic [RATE_W-1:0] dsr_r, dsr_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [INC_W-1:0]  q_r, q_nxt;
  logic [RATE_W:0]   trial;
  logic              ge;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign ge = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    dvd_nxt = dvd_r;
    q_nxt = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = 5'(DVD_W - 1);
      rem_nxt = '0;
      dsr_nxt = (divisor == '0) ? RATE_W'(1) : divisor;
      dvd_nxt = {tone_hz, {INC_W{1'b0}}};
      q_nxt = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? RATE_W'(trial - {1'b0, dsr_r}) : trial[RATE_W-1:0];
      q_nxt = {q_r[INC_W-2:0], ge};
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    dvd_r <= dvd_nxt;
    q_r <= q_nxt;
  end

  assign done = done_r;
  assign quotient = q_r;

endmodule

// ===== rtl/core/dstg_voice.sv =====
module dstg_voice
  import dstg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  voice_ctl_t        ctl,
  input  logic [INC_W-1:0]  inc_val,
  output logic signed [2:0] sample
);

  logic [INC_W-1:0] inc_r [2];
  logic [INC_W-1:0] inc_nxt [2];
  logic [INC_W-1:0] acc_r [2];
  logic [INC_W-1:0] acc_nxt [2];
  logic [INC_W-1:0] acc_sum [2];
  logic signed [2:0] lvl [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      acc_sum[i] = acc_r[i] + inc_r[i];
      if (inc_r[i] == '0) begin
        lvl[i] = 3'sd0;
      end else if (acc_sum[i][INC_W-1]) begin
        lvl[i] = -3'sd1;
      end else begin
        lvl[i] = 3'sd1;
      end
      inc_nxt[i] = inc_r[i];
      acc_nxt[i] = acc_r[i];
      if (ctl.step) begin
        acc_nxt[i] = acc_sum[i];
      end
      if (ctl.clr_all || (ctl.clr_one && (ctl.ch == 1'(i)))) begin
        inc_nxt[i] = '0;
      end else if (ctl.set_inc && (ctl.ch == 1'(i))) begin
        inc_nxt[i] = inc_val;
      end
    end
  end

  assign sample = lvl[0] + lvl[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        inc_r[i] <= '0;
        acc_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < 2; i++) begin
        inc_r[i] <= inc_nxt[i];
        acc_r[i] <= acc_nxt[i];
      end
    end
  end

endmodule

// ===== rtl/core/dual_square_tone_generator.sv =====
// Channel  Dir  Handshake          Word
// in_      in   in_valid/in_stall  command, channel, tone_hz, cyc_elapsed
// out_     out  out_valid/out_stall sample, last
// cfg_     in   cfg_valid/cfg_ready index 0 sample_period_scaled, 1 sound_rate
// A start command runs the one shared restoring divider, which makes one
// quotient bit per cycle over 31 steps. Stop commands complete in the idle state.
// A tick emits one sample per cycle while the output register is drained;
// a stalled output holds the sequencer.
// Reset is synchronous and needs no clearing pass.
module dual_square_tone_generator
  import dstg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_word_t            in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output out_word_t           out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  cfg_idx_t            cfg_index,
  input  logic [PERIOD_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_TICK = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  logic signed [TIMER_W-1:0]  timer_r, timer_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       ch_r, ch_nxt;
  logic [PERIOD_W-1:0]        period_r;
  logic [RATE_W-1:0]          rate_r;
  logic                       out_valid_r, out_valid_nxt;
  out_word_t                  out_word_r, out_word_nxt;
  logic                       in_acc;
  logic                       slot_free;
  logic                       due;
  logic [PERIOD_W-1:0]        period_eff;
  logic signed [TIMER_W-1:0]  timer_sum;
  logic                       div_start;
  logic                       div_done;
  logic [INC_W-1:0]           div_q;
  voice_ctl_t                 vctl;
  logic signed [2:0]          mix;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc = in_valid && (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign due = timer_r[TIMER_W-1] && (cnt_r != MAX_SAMPLES);
  assign period_eff = (period_r < MIN_PERIOD) ? MIN_PERIOD : period_r;
  assign timer_sum = timer_r + $signed({2'b00, period_eff});

  always_comb begin
    state_nxt = state_r;
    timer_nxt = timer_r;
    cnt_nxt = cnt_r;
    ch_nxt = ch_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt = out_word_r;
    div_start = 1'b0;
    vctl = '0;
    vctl.ch = ch_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          vctl.ch = in_word.channel;
          case (in_word.command)
            CMD_TICK: begin
              timer_nxt = timer_r - TIMER_W'(in_word.cyc_elapsed * PRECISION);
              cnt_nxt = '0;
              state_nxt = ST_TICK;
            end
            CMD_START: begin
              ch_nxt = in_word.channel;
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end
            CMD_STOP: begin
              vctl.clr_one = 1'b1;
            end
            CMD_STOP_ALL: begin
              vctl.clr_all = 1'b1;
            end
            default: begin
              vctl.clr_all = 1'b0;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          vctl.set_inc = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (!due) begin
          if (timer_r[TIMER_W-1]) begin
            timer_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          vctl.step = 1'b1;
          timer_nxt = timer_sum;
          cnt_nxt = cnt_r + CNT_W'(1);
          out_valid_nxt = 1'b1;
          out_word_nxt.sample = mix;
          out_word_nxt.last = !timer_sum[TIMER_W-1] || (cnt_r == MAX_SAMPLES - CNT_W'(1));
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      timer_r <= '0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      period_r <= PERIOD_RESET;
      rate_r <= RATE_RESET;
    end else begin
      state_r <= state_nxt;
      timer_r <= timer_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SAMPLE_PERIOD: period_r <= cfg_wdata;
          CFG_SOUND_RATE: rate_r <= cfg_wdata[RATE_W-1:0];
          default: period_r <= period_r;
        endcase
      end
    end
    ch_r <= ch_nxt;
    out_word_r <= out_word_nxt;
  end

  dstg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .tone_hz  (in_word.tone_hz),
    .divisor  (rate_r),
    .done     (div_done),
    .quotient (div_q)
  );

  dstg_voice u_voice (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (vctl),
    .inc_val (div_q),
    .sample  (mix)
  );

  assign out_valid = out_valid_r;
  assign out_word = out_word_r;

  a_word_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_TICK))
    else $error("output word appeared outside a tick");

  a_sample_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TICK && cnt_r == MAX_SAMPLES) |=> state_r == ST_IDLE)
    else $error("tick ran past the sample limit");

  a_idle_timer: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !timer_r[TIMER_W-1])
    else $error("sample timer negative while idle");

endmodule
